// ===== design/ptev_pkg.sv =====
// ----------------------------------------------------------------------------
// ptev_pkg
// Shared opcodes, field widths and the command, status and result bundles
// of the polynomial table evaluator.
// ----------------------------------------------------------------------------
package ptev_pkg;

  // Field widths of one request and one result
  localparam int unsigned OP_W   = 3;
  localparam int unsigned EXP_W  = 5;
  localparam int unsigned DATA_W = 32;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ASSIGN = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_EVAL   = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;     // capture the incoming request
    logic issue;     // start the operation, launch the first table read
    logic rd_use;    // consume the table read data
    logic mul;       // multiply accumulator by x, launch next read
    logic acc;       // scale, add coefficient, saturate
    logic write;     // write the coefficient and update the degree
    logic scan;      // one step of the downward degree scan
    logic out_load;  // hand the result to the output register
  } ptev_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cnt_zero;
    logic            shrink;
    logic            scan_hit;
  } ptev_status_t;

  // One result item
  typedef struct packed {
    logic              overflow;
    logic [EXP_W-1:0]  degree_now;
    logic [DATA_W-1:0] result_value;
  } ptev_result_t;

endpackage

// ===== design/ptev_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptev_ctrl
// Sequencer of the evaluator: walks each request through issue, table read,
// Horner steps, write-back, degree scan and result hand-off.
// ----------------------------------------------------------------------------
module ptev_ctrl
  import ptev_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         out_free_i,
  input  ptev_status_t sts_i,
  output logic         in_ready_o,
  output ptev_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd_o.issue = 1'b1;
        unique case (sts_i.op)
          OP_ASSIGN: state_d = S_WRITE;
          OP_ADD,
          OP_READ,
          OP_EVAL:   state_d = S_READ;
          default:   state_d = S_DONE;
        endcase
      end
      S_READ: begin
        cmd_o.rd_use = 1'b1;
        if (sts_i.op == OP_ADD) begin
          state_d = S_WRITE;
        end else if (sts_i.op == OP_EVAL && !sts_i.cnt_zero) begin
          state_d = S_MUL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.cnt_zero ? S_DONE : S_MUL;
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = sts_i.shrink ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/ptev_datapath.sv =====
// ----------------------------------------------------------------------------
// ptev_datapath
// Coefficient memory with nonzero flags, degree register, shared Q15.16
// multiplier and saturating adder for Horner evaluation.
// ----------------------------------------------------------------------------
module ptev_datapath
  import ptev_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptev_cmd_t         cmd_i,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [EXP_W-1:0]  exponent_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] point_i,
  output ptev_status_t      sts_o,
  output ptev_result_t      res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0]        mem [CAPACITY];
  logic [DATA_W-1:0]        rd_q;
  logic                     rd_nz_q;
  logic [CAPACITY-1:0]      nz_q;
  logic [OP_W-1:0]          op_q;
  logic [AW-1:0]            addr_q;
  logic [AW-1:0]            deg_q;
  logic [AW-1:0]            cnt_q;
  logic signed [DATA_W-1:0] x_q;
  logic signed [DATA_W-1:0] res_q;
  logic signed [63:0]       prod_q;
  logic                     ovf_q;

  logic [31:0]              exp_ext;
  logic [31:0]              exp_clamp;
  logic [AW-1:0]            cnt_dec;
  logic [AW-1:0]            rd_addr;
  logic                     rd_en;
  logic [DATA_W-1:0]        coef;
  logic [63:0]              scaled;
  logic                     prod_ovf;
  logic [DATA_W-1:0]        prod_sat;
  logic [DATA_W:0]          hsum;
  logic                     hsum_ovf;
  logic [DATA_W-1:0]        hsum_sat;
  logic [DATA_W:0]          asum;
  logic                     asum_ovf;
  logic [DATA_W-1:0]        asum_sat;
  logic                     grow;
  logic [31:0]              deg_ext;

  // Clamp the exponent to the table
  always_comb begin
    exp_ext   = 32'(exponent_i);
    exp_clamp = (exp_ext >= CAPACITY) ? 32'(CAPACITY - 1) : exp_ext;
  end

  assign cnt_dec = cnt_q - AW'(1);
  assign coef    = rd_nz_q ? rd_q : '0;

  // Read address: degree at issue for evaluate, the next lower term per step
  always_comb begin
    rd_en   = cmd_i.issue | cmd_i.mul;
    rd_addr = addr_q;
    if (cmd_i.mul) begin
      rd_addr = cnt_dec;
    end else if (op_q == OP_EVAL) begin
      rd_addr = deg_q;
    end
  end

  // Product: floor shift by 16, then saturate; add coefficient, saturate
  always_comb begin
    scaled   = 64'(prod_q >>> 16);
    prod_ovf = !((&scaled[63:DATA_W-1]) || !(|scaled[63:DATA_W-1]));
    prod_sat = prod_ovf ? (scaled[63] ? SAT_MIN : SAT_MAX) : scaled[DATA_W-1:0];
    hsum     = {prod_sat[DATA_W-1], prod_sat} + {coef[DATA_W-1], coef};
    hsum_ovf = hsum[DATA_W] ^ hsum[DATA_W-1];
    hsum_sat = hsum_ovf ? (hsum[DATA_W] ? SAT_MIN : SAT_MAX) : hsum[DATA_W-1:0];
    asum     = {res_q[DATA_W-1], res_q} + {coef[DATA_W-1], coef};
    asum_ovf = asum[DATA_W] ^ asum[DATA_W-1];
    asum_sat = asum_ovf ? (asum[DATA_W] ? SAT_MIN : SAT_MAX) : asum[DATA_W-1:0];
  end

  assign grow          = (addr_q > deg_q) && (res_q != '0);
  assign sts_o.shrink  = (addr_q == deg_q) && (res_q == '0) && (deg_q != '0);
  assign sts_o.op      = op_q;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.scan_hit = nz_q[cnt_dec] || (cnt_dec == '0);

  // Coefficient memory write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem[addr_q] <= res_q;
    end
  end

  // Coefficient memory read port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_nz_q <= nz_q[rd_addr];
    end
  end

  // Request capture and Horner datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= opcode_i;
      addr_q <= exp_clamp[AW-1:0];
      res_q  <= value_i;
      x_q    <= point_i;
    end
    if (cmd_i.issue) begin
      ovf_q <= 1'b0;
      if (op_q != OP_ASSIGN && op_q != OP_ADD) begin
        res_q <= '0;
      end
    end
    if (cmd_i.rd_use) begin
      if (op_q == OP_ADD) begin
        res_q <= asum_sat;
        ovf_q <= asum_ovf;
      end else begin
        res_q <= coef;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= res_q * x_q;
    end
    if (cmd_i.acc) begin
      res_q <= hsum_sat;
      ovf_q <= ovf_q | prod_ovf | hsum_ovf;
    end
  end

  // Nonzero flags, degree and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q  <= '0;
      deg_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.issue) begin
        cnt_q <= deg_q;
        if (op_q == OP_CLEAR) begin
          nz_q  <= '0;
          deg_q <= '0;
        end
      end
      if (cmd_i.mul) begin
        cnt_q <= cnt_dec;
      end
      if (cmd_i.write) begin
        nz_q[addr_q] <= (res_q != '0);
        if (grow) begin
          deg_q <= addr_q;
        end else if (sts_o.shrink) begin
          cnt_q <= deg_q;
        end
      end
      if (cmd_i.scan) begin
        cnt_q <= cnt_dec;
        if (sts_o.scan_hit) begin
          deg_q <= cnt_dec;
        end
      end
    end
  end

  // Result fields
  assign deg_ext             = 32'(deg_q);
  assign res_o.result_value  = res_q;
  assign res_o.degree_now    = deg_ext[EXP_W-1:0];
  assign res_o.overflow      = ovf_q;

endmodule

// ===== design/polynomial_table_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// polynomial_table_evaluator_core
// Coefficient table with assign, add, clear, read and Horner evaluation in
// signed Q15.16, with saturating arithmetic and an overflow flag.
// ----------------------------------------------------------------------------
//  Channel   Dir  Bits  Contents (lowest bit first)
//  s_axis    in   72    opcode[2:0], exponent[7:3], value[39:8], point[71:40]
//  m_axis    out  40    result_value[31:0], degree_now[36:32], overflow[37], 0
//
//  Add and assign may each be followed by up to degree steps of the downward
//  degree scan. Evaluation is paced by the shared multiplier: one multiply
//  and one accumulate per term.
//  Reset clears the degree and all nonzero flags at once; no clearing pass.
//  A request is taken while a previous result waits on m_axis; its result
//  holds in the datapath until the output register frees up.
// ----------------------------------------------------------------------------
module polynomial_table_evaluator_core
  import ptev_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // opcode, exponent, value, point
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // result_value, degree_now, overflow, pad
);

  ptev_cmd_t    cmd;
  ptev_status_t sts;
  ptev_result_t res;
  logic         out_free;
  logic         m_valid_q;
  logic [39:0]  m_data_q;

  assign out_free = !m_valid_q || m_axis_tready_i;

  ptev_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  ptev_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .opcode_i   (s_axis_tdata_i[2:0]),
    .exponent_i (s_axis_tdata_i[7:3]),
    .value_i    (s_axis_tdata_i[39:8]),
    .point_i    (s_axis_tdata_i[71:40]),
    .sts_o      (sts),
    .res_o      (res)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output register data
  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      m_data_q <= {2'b00, res.overflow, res.degree_now, res.result_value};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
